// ===== design/scd3_pkg.sv =====
package scd3_pkg;

    localparam int DefMaxDim  = 64;
    localparam int DefInfDist = 30000;

    localparam int AddrW  = 18;
    localparam int DimW   = 7;
    localparam int CoordW = 6;
    localparam int DistW  = 16;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_COMPUTE = 2'd1;
    localparam logic [1:0] OP_READ    = 2'd2;

    localparam logic [1:0] REG_SIZE_X = 2'd0;
    localparam logic [1:0] REG_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_SIZE_Z = 2'd2;

    localparam logic [3:0] LABEL_LAST = 4'd6;
    localparam logic [3:0] RELAX_LAST = 4'd13;

    typedef struct packed {
        logic signed [1:0] dx;
        logic signed [1:0] dy;
        logic signed [1:0] dz;
        logic [4:0]        w;
    } nbr_t;

    // Neighbor offsets: the six face neighbors for labeling (self first),
    // the forward half-mask for relaxation, negated for the reverse pass.
    function automatic nbr_t nbr_lookup(input logic is_label, input logic is_rev,
                                        input logic [3:0] m);
        nbr_t n;
        n = '{dx: 2'sd0, dy: 2'sd0, dz: 2'sd0, w: 5'd0};
        if (is_label) begin
            case (m)
                4'd1: n.dx = 2'sd1;
                4'd2: n.dx = -2'sd1;
                4'd3: n.dy = 2'sd1;
                4'd4: n.dy = -2'sd1;
                4'd5: n.dz = 2'sd1;
                4'd6: n.dz = -2'sd1;
                default: n = n;
            endcase
        end else begin
            case (m)
                4'd1:  n = '{dx: 2'sd0,  dy: 2'sd1, dz: 2'sd0,  w: 5'd10};
                4'd2:  n = '{dx: -2'sd1, dy: 2'sd0, dz: 2'sd0,  w: 5'd10};
                4'd3:  n = '{dx: 2'sd0,  dy: 2'sd0, dz: -2'sd1, w: 5'd10};
                4'd4:  n = '{dx: 2'sd0,  dy: 2'sd1, dz: -2'sd1, w: 5'd14};
                4'd5:  n = '{dx: -2'sd1, dy: 2'sd0, dz: -2'sd1, w: 5'd14};
                4'd6:  n = '{dx: 2'sd1,  dy: 2'sd0, dz: -2'sd1, w: 5'd14};
                4'd7:  n = '{dx: -2'sd1, dy: 2'sd1, dz: 2'sd0,  w: 5'd14};
                4'd8:  n = '{dx: 2'sd1,  dy: 2'sd1, dz: 2'sd0,  w: 5'd14};
                4'd9:  n = '{dx: 2'sd0,  dy: 2'sd1, dz: 2'sd1,  w: 5'd14};
                4'd10: n = '{dx: -2'sd1, dy: 2'sd1, dz: -2'sd1, w: 5'd17};
                4'd11: n = '{dx: 2'sd1,  dy: 2'sd1, dz: -2'sd1, w: 5'd17};
                4'd12: n = '{dx: -2'sd1, dy: 2'sd1, dz: 2'sd1,  w: 5'd17};
                4'd13: n = '{dx: 2'sd1,  dy: 2'sd1, dz: 2'sd1,  w: 5'd17};
                default: n = n;
            endcase
            if (is_rev) begin
                n.dx = -n.dx;
                n.dy = -n.dy;
                n.dz = -n.dz;
            end
        end
        return n;
    endfunction

endpackage

// ===== design/signed_chamfer_distance_3d_unit.sv =====
// Channel  | Direction | Handshake          | Contents
// s_       | in        | s_tvalid/s_tready  | tuser: op; tdata: voxel_index, occupied
// m_       | out       | m_tvalid/m_tready  | tdata: distance; tuser: done_res
// cfg_     | in        | cfg_wr_en          | cfg_index selects size_x/y/z
//
// A load item writes the occupancy store; a read item passes through one
// memory read and the output register. A compute item walks the volume with
// one shared neighbor-fetch and compare unit, paced by the single read port
// of the distance memory: a labeling pass, then a forward and a reverse
// raster pass. Reset is synchronous, active low, and clears only control
// state; the memories hold no reset value.
// The input is held off while a compute or a read runs and while a result waits.
module signed_chamfer_distance_3d_unit #(
    parameter int MAX_DIM  = scd3_pkg::DefMaxDim,
    parameter int INF_DIST = scd3_pkg::DefInfDist
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [17:0] voxel_index, [18] occupied, zero fill
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] distance
    output logic        m_tuser,   // [0] done_res
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import scd3_pkg::*;

    // Extents are capped so the volume always fits the stores.
    localparam int DimCap = (MAX_DIM < 64) ? MAX_DIM : 64;
    localparam logic [DimW-1:0] CapV = DimW'(DimCap);
    localparam logic signed [16:0] InfP = 17'(INF_DIST);
    localparam logic signed [16:0] InfN = -17'(INF_DIST);
    localparam int Depth = 1 << AddrW;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RDWAIT, ST_SETUP1, ST_SETUP2, ST_START, ST_SCAN, ST_WRITE, ST_DONE
    } state_t;
    typedef enum logic [1:0] {PH_LABEL, PH_FWD, PH_REV} phase_t;

    state_t state_reg;
    phase_t phase_reg;
    logic [DimW-1:0] sx_reg, sy_reg, sz_reg;
    logic [DimW-1:0] ex, ey, ez;
    logic [12:0] sxy_reg, lastrow_reg;
    logic [AddrW-1:0] lastslab_reg, row_reg;
    logic [CoordW-1:0] i_reg, j_reg, k_reg;
    logic [3:0] m_reg;
    logic inside_d_reg;
    logic [4:0] w_d_reg;
    logic signed [DistW-1:0] v_reg;
    logic signed [16:0] best_reg;
    logic self_reg, touch_reg;
    logic m_valid_reg;
    logic [15:0] m_data_reg;
    logic m_user_reg;

    // Memories and their registered read data.
    logic occ_mem [Depth];
    logic [DistW-1:0] dist_mem [Depth];
    logic occ_q_reg;
    logic [DistW-1:0] dist_q_reg;

    logic accept;
    logic [1:0] op;
    logic [AddrW-1:0] in_index;
    nbr_t nb;
    logic [3:0] last_m;
    logic is_label;
    logic i_up, j_up, k_up;
    logic signed [7:0] ni, nj, nk;
    logic in_vol;
    logic signed [AddrW:0] off;
    logic [AddrW-1:0] naddr, cur_addr;
    logic signed [16:0] nbv, cand, best_init, best_cur, best_new;
    logic pos, first;
    logic [3:0] e_idx;
    logic signed [DistW-1:0] lab_val, sat_val, write_val;
    logic is_seed, do_write;

    function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
        if (v == '0) return DimW'(1);
        if (v > CapV) return CapV;
        return v;
    endfunction

    assign ex = eff_dim(sx_reg);
    assign ey = eff_dim(sy_reg);
    assign ez = eff_dim(sz_reg);

    assign op       = s_tuser;
    assign in_index = s_tdata[AddrW-1:0];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign is_label = (phase_reg == PH_LABEL);
    assign i_up     = (phase_reg != PH_REV);
    assign j_up     = (phase_reg != PH_FWD);
    assign k_up     = (phase_reg != PH_REV);
    assign last_m   = is_label ? LABEL_LAST : RELAX_LAST;
    assign nb       = nbr_lookup(is_label, phase_reg == PH_REV, m_reg);

    // Neighbor coordinates and linear address of the current mask entry.
    always_comb begin
        ni = $signed({2'b00, i_reg}) + 8'(nb.dx);
        nj = $signed({2'b00, j_reg}) + 8'(nb.dy);
        nk = $signed({2'b00, k_reg}) + 8'(nb.dz);
        in_vol = (ni >= 0) && (ni < $signed({1'b0, ex}))
              && (nj >= 0) && (nj < $signed({1'b0, ey}))
              && (nk >= 0) && (nk < $signed({1'b0, ez}));
        off = (AddrW+1)'(nb.dx);
        if (nb.dy == 2'sd1)       off = off + $signed({12'd0, ex});
        else if (nb.dy == -2'sd1) off = off - $signed({12'd0, ex});
        if (nb.dz == 2'sd1)       off = off + $signed({6'd0, sxy_reg});
        else if (nb.dz == -2'sd1) off = off - $signed({6'd0, sxy_reg});
        cur_addr = row_reg + AddrW'(i_reg);
        naddr = AddrW'($signed({1'b0, cur_addr}) + off);
    end

    // Shared compare unit: one neighbor per cycle, data of the entry issued last cycle.
    always_comb begin
        e_idx = m_reg - 4'd1;
        first = (e_idx == 4'd0);
        pos = first ? ($signed(dist_q_reg) > 0) : (v_reg > 0);
        best_init = pos ? InfP : InfN;
        if (inside_d_reg) nbv = 17'($signed(dist_q_reg));
        else              nbv = best_init;
        cand = pos ? (nbv + $signed({12'd0, w_d_reg})) : (nbv - $signed({12'd0, w_d_reg}));
        best_cur = first ? best_init : best_reg;
        if (pos) best_new = (cand < best_cur) ? cand : best_cur;
        else     best_new = (cand > best_cur) ? cand : best_cur;
    end

    always_comb begin
        if (touch_reg) lab_val = self_reg ? -16'sd5 : 16'sd5;
        else           lab_val = self_reg ? 16'(InfN) : 16'(InfP);
        if (best_reg > 17'sd32767)       sat_val = 16'sh7fff;
        else if (best_reg < -17'sd32768) sat_val = 16'sh8000;
        else                             sat_val = best_reg[15:0];
        is_seed = (v_reg == 16'sd5) || (v_reg == -16'sd5);
        write_val = is_label ? lab_val : sat_val;
        do_write = (state_reg == ST_WRITE) && (is_label || !is_seed);
    end

    always_ff @(posedge aclk) begin
        if (accept && op == OP_LOAD) begin
            occ_mem[in_index] <= s_tdata[AddrW];
        end
        occ_q_reg <= occ_mem[naddr];
    end

    always_ff @(posedge aclk) begin
        if (do_write) begin
            dist_mem[cur_addr] <= write_val;
        end
        dist_q_reg <= dist_mem[(state_reg == ST_IDLE) ? in_index : naddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= PH_LABEL;
            sx_reg      <= 7'd64;
            sy_reg      <= 7'd64;
            sz_reg      <= 7'd64;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_SIZE_X: sx_reg <= cfg_data;
                    REG_SIZE_Y: sy_reg <= cfg_data;
                    REG_SIZE_Z: sz_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        case (op)
                            OP_COMPUTE: state_reg <= ST_SETUP1;
                            OP_READ:    state_reg <= ST_RDWAIT;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_RDWAIT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= dist_q_reg;
                    m_user_reg  <= 1'b0;
                    state_reg   <= ST_IDLE;
                end
                ST_SETUP1: begin
                    sxy_reg   <= 13'(ex) * 13'(ey);
                    phase_reg <= PH_LABEL;
                    state_reg <= ST_SETUP2;
                end
                ST_SETUP2: begin
                    lastrow_reg  <= sxy_reg - 13'(ex);
                    lastslab_reg <= AddrW'(ez - 7'd1) * AddrW'(sxy_reg);
                    state_reg    <= ST_START;
                end
                ST_START: begin
                    i_reg <= i_up ? '0 : CoordW'(ex - 7'd1);
                    j_reg <= j_up ? '0 : CoordW'(ey - 7'd1);
                    k_reg <= k_up ? '0 : CoordW'(ez - 7'd1);
                    row_reg <= (k_up ? '0 : lastslab_reg)
                             + (j_up ? '0 : AddrW'(lastrow_reg));
                    m_reg <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (m_reg <= last_m) begin
                        inside_d_reg <= in_vol;
                        w_d_reg      <= nb.w;
                    end
                    if (m_reg != 4'd0) begin
                        if (is_label) begin
                            if (first) begin
                                self_reg  <= occ_q_reg;
                                touch_reg <= 1'b0;
                            end else begin
                                touch_reg <= touch_reg | (inside_d_reg & occ_q_reg);
                            end
                        end else begin
                            if (first) v_reg <= $signed(dist_q_reg);
                            best_reg <= best_new;
                        end
                    end
                    if (m_reg == last_m + 4'd1) state_reg <= ST_WRITE;
                    m_reg <= m_reg + 4'd1;
                end
                ST_WRITE: begin
                    m_reg     <= '0;
                    state_reg <= ST_SCAN;
                    if (i_up ? ({1'b0, i_reg} != ex - 7'd1) : (i_reg != '0)) begin
                        i_reg <= i_up ? i_reg + 6'd1 : i_reg - 6'd1;
                    end else begin
                        i_reg <= i_up ? '0 : CoordW'(ex - 7'd1);
                        if (j_up ? ({1'b0, j_reg} != ey - 7'd1) : (j_reg != '0)) begin
                            j_reg   <= j_up ? j_reg + 6'd1 : j_reg - 6'd1;
                            row_reg <= j_up ? row_reg + AddrW'(ex) : row_reg - AddrW'(ex);
                        end else begin
                            j_reg <= j_up ? '0 : CoordW'(ey - 7'd1);
                            if (k_up ? ({1'b0, k_reg} != ez - 7'd1) : (k_reg != '0)) begin
                                k_reg <= k_up ? k_reg + 6'd1 : k_reg - 6'd1;
                                row_reg <= row_reg
                                         - (j_up ? AddrW'(lastrow_reg) : '0)
                                         + (j_up ? '0 : AddrW'(lastrow_reg))
                                         + (k_up ? AddrW'(sxy_reg) : -AddrW'(sxy_reg));
                            end else begin
                                case (phase_reg)
                                    PH_LABEL: begin
                                        phase_reg <= PH_FWD;
                                        state_reg <= ST_START;
                                    end
                                    PH_FWD: begin
                                        phase_reg <= PH_REV;
                                        state_reg <= ST_START;
                                    end
                                    default: state_reg <= ST_DONE;
                                endcase
                            end
                        end
                    end
                end
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= '0;
                    m_user_reg  <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
